// ----- sv/irbps_pkg.sv -----
package irbps_pkg;

	localparam int DEF_TABLE_ENTRIES = 8;
	localparam int DEF_CODE_BYTES    = 32;

	localparam logic [1:0] CMD_LOAD_TABLE = 2'd0;
	localparam logic [1:0] CMD_LOAD_CODE  = 2'd1;
	localparam logic [1:0] CMD_ARM        = 2'd2;
	localparam logic [1:0] CMD_SEND       = 2'd3;

	localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [1:0] REG_REPEAT_COUNT = 2'd1;
	localparam logic [1:0] REG_CARRIER_RAW  = 2'd2;

	localparam logic [6:0] MAX_SYMBOLS    = 7'd64;
	localparam logic [7:0] REPEAT_FOREVER = 8'hFF;

	localparam logic STATUS_PULSE = 1'b0;
	localparam logic STATUS_IDLE  = 1'b1;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  slot;
		logic [15:0] mark_time;
		logic [15:0] space_time;
		logic [7:0]  code_byte;
	} in_word_t;

	typedef struct packed {
		logic        status;
		logic [17:0] period_ticks;
		logic [16:0] space_ticks;
		logic [16:0] carrier_compare;
		logic [5:0]  symbol_number;
		logic        last;
		logic        finished;
	} out_word_t;

	typedef struct packed {
		logic wr_table;
		logic wr_code;
		logic arm;
		logic send;
		logic emit_idle;
		logic emit_sym;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic n_zero;
		logic sym_last;
	} ctrl_stat_t;

endpackage

// ----- sv/irbps_ctrl.sv -----
module irbps_ctrl
	import irbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd,
	output logic       busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_LOAD_TABLE: cmd.wr_table = 1'b1;
						CMD_LOAD_CODE:  cmd.wr_code  = 1'b1;
						CMD_ARM:        cmd.arm      = 1'b1;
						CMD_SEND: begin
							cmd.send = 1'b1;
							if (stat.rem_zero || stat.n_zero) begin
								cmd.emit_idle = 1'b1;
							end else begin
								state_d = ST_RUN;
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_RUN: begin
				cmd.emit_sym = 1'b1;
				if (stat.sym_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/irbps_datapath.sv -----
module irbps_datapath
	import irbps_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int CODE_BYTES    = DEF_CODE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_word_t    request,
	input  ctrl_cmd_t   cmd,
	output ctrl_stat_t  stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output out_word_t   result
);

	localparam int TIW = $clog2(TABLE_ENTRIES);
	localparam int CIW = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;

	logic [15:0] mark_q  [TABLE_ENTRIES];
	logic [15:0] space_q [TABLE_ENTRIES];
	logic [7:0]  code_q  [CODE_BYTES];

	logic [6:0]  symbol_count_q;
	logic [7:0]  repeat_count_q;
	logic [15:0] carrier_raw_q;
	logic [7:0]  rem_q;
	logic [6:0]  n_q;
	logic [5:0]  i_q;
	logic        fin_q;
	logic        strobe_q;
	out_word_t   result_q;

	logic [4:0]  pos;
	logic [7:0]  byte_rd;
	logic [2:0]  sym;
	logic [15:0] mk;
	logic [15:0] sp;
	logic [16:0] pair_sum;
	logic [19:0] f_scaled;
	logic [16:0] cmp;
	logic        fin_now;

	assign stat.rem_zero = (rem_q == 8'd0);
	assign stat.n_zero   = (symbol_count_q == 7'd0);
	assign stat.sym_last = ((7'(i_q) + 7'd1) == n_q);

	assign fin_now = (rem_q == 8'd0) || (rem_q == 8'd1);

	assign pos     = i_q[5:1];
	assign byte_rd = (32'(pos) < CODE_BYTES) ? code_q[pos[CIW-1:0]] : 8'd0;
	assign sym     = i_q[0] ? byte_rd[2:0] : byte_rd[6:4];

	always_comb begin
		if (32'(sym) < TABLE_ENTRIES) begin
			mk = mark_q[sym[TIW-1:0]];
			sp = space_q[sym[TIW-1:0]];
		end else begin
			mk = 16'd0;
			sp = 16'd0;
		end
	end

	assign pair_sum = {1'b0, mk} + {1'b0, sp};
	assign f_scaled = ({4'd0, carrier_raw_q} << 4) - ({4'd0, carrier_raw_q} << 1);
	assign cmp      = {1'b0, carrier_raw_q} + {2'b00, f_scaled[19:5]} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				mark_q[k]  <= 16'd0;
				space_q[k] <= 16'd0;
			end
			for (int k = 0; k < CODE_BYTES; k++) begin
				code_q[k] <= 8'd0;
			end
			symbol_count_q <= 7'd0;
			repeat_count_q <= 8'd0;
			carrier_raw_q  <= 16'd0;
			rem_q          <= 8'd0;
			n_q            <= 7'd0;
			i_q            <= 6'd0;
			fin_q          <= 1'b0;
			strobe_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SYMBOL_COUNT: symbol_count_q <= cfg_data[6:0];
					REG_REPEAT_COUNT: repeat_count_q <= cfg_data[7:0];
					REG_CARRIER_RAW:  carrier_raw_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.wr_table && (32'(request.slot) < TABLE_ENTRIES)) begin
				mark_q[request.slot[TIW-1:0]]  <= request.mark_time;
				space_q[request.slot[TIW-1:0]] <= request.space_time;
			end
			if (cmd.wr_code && (32'(request.slot) < CODE_BYTES)) begin
				code_q[request.slot[CIW-1:0]] <= request.code_byte;
			end
			if (cmd.arm) begin
				rem_q <= repeat_count_q;
			end
			if (cmd.send) begin
				if (rem_q != 8'd0 && rem_q != REPEAT_FOREVER) begin
					rem_q <= rem_q - 8'd1;
				end
				fin_q <= fin_now;
				n_q   <= (symbol_count_q > MAX_SYMBOLS) ? MAX_SYMBOLS : symbol_count_q;
				i_q   <= 6'd0;
			end
			if (cmd.emit_sym) begin
				i_q <= i_q + 6'd1;
			end
			strobe_q <= cmd.emit_idle || cmd.emit_sym;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_idle) begin
			result_q.status          <= STATUS_IDLE;
			result_q.period_ticks    <= 18'd0;
			result_q.space_ticks     <= 17'd0;
			result_q.carrier_compare <= 17'd0;
			result_q.symbol_number   <= 6'd0;
			result_q.last            <= 1'b1;
			result_q.finished        <= fin_now;
		end else if (cmd.emit_sym) begin
			result_q.status          <= STATUS_PULSE;
			result_q.period_ticks    <= {pair_sum, 1'b0};
			result_q.space_ticks     <= {sp, 1'b0};
			result_q.carrier_compare <= cmp;
			result_q.symbol_number   <= i_q;
			result_q.last            <= stat.sym_last;
			result_q.finished        <= stat.sym_last && fin_q;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- sv/ir_burst_pattern_sequencer_unit.sv -----
// Channel   Handshake              Payload
// command   start / busy           request (in_word_t)
// result    strobe, one cycle      result (out_word_t)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Loads and arm give no word. A send gives one word the cycle after acceptance
// when the repeat count left is zero or there are no symbols, otherwise one word
// per cycle for n symbols (n up to 64), the first after the state register enters
// run and the result register takes symbol 0. busy is high while the symbols are
// walked. Reset clears the stores, the repeat counter and the registers but the
// result word. cfg_ready is always high; the receiver cannot stall.
module ir_burst_pattern_sequencer_unit
	import irbps_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int CODE_BYTES    = DEF_CODE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    request,
	output logic        strobe,
	output out_word_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign cfg_ready = 1'b1;

	irbps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	irbps_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.CODE_BYTES    (CODE_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

// ----- sv/irbps_checker.sv -----
module irbps_checker
	import irbps_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_word_t  request,
	input logic      strobe,
	input out_word_t result
);

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("burst broken before its last word");

	a_busy_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("not busy during a burst");

	a_symbol_advance: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> result.symbol_number == $past(result.symbol_number) + 6'd1)
		else $error("symbol number did not advance");

	a_idle_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == STATUS_IDLE |-> result.last && result.period_ticks == 18'd0
			&& result.symbol_number == 6'd0)
		else $error("idle word malformed");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.command != CMD_SEND |=> !strobe)
		else $error("word after a load or arm");

endmodule

bind ir_burst_pattern_sequencer_unit irbps_checker u_irbps_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.strobe  (strobe),
	.result  (result)
);
